### hw/rtl/assert_macros.svh
// assertion macros used by the hill cipher checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define HILL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hill cipher assertion failed");

// next-cycle implication, disabled while reset is low
`define HILL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hill cipher assertion failed");

`endif

### hw/rtl/hill_pkg.sv
// shared types, constants and modulo-26 helpers for the hill cipher block
package hill_pkg;

    localparam int LETTER_W = 5;
    localparam int INDEX_W  = 3;

    localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
    localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

    // configuration register indexes
    typedef enum logic [INDEX_W-1:0] {
        REG_KEY_R0C0 = 3'd0,
        REG_KEY_R0C1 = 3'd1,
        REG_KEY_R1C0 = 3'd2,
        REG_KEY_R1C1 = 3'd3,
        REG_MODE     = 3'd4
    } reg_index_t;

    // operand sets of the shared multiply-accumulate unit
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_DET   = 3'd1,
        OP_ROW0  = 3'd2,
        OP_ROW1  = 3'd3,
        OP_SCALE = 3'd4
    } op_t;

    // source of an emitted result item
    typedef enum logic [1:0] {
        EMIT_MAC    = 2'd0,
        EMIT_SCALED = 2'd1,
        EMIT_LONE   = 2'd2
    } emit_t;

    // controller to datapath commands
    typedef struct packed {
        logic  load_first;
        logic  load_second;
        logic  load_pad;
        op_t   op;
        logic  latch_det;
        logic  latch_t;
        logic  emit;
        emit_t emit_kind;
        logic  emit_last;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic decrypt;
        logic out_free;
    } status_t;

    // inverse lookup result
    typedef struct packed {
        logic                ok;
        logic [LETTER_W-1:0] value;
    } inv_t;

    // reduce a 5-bit value into 0..25
    function automatic logic [LETTER_W-1:0] reduce26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        r = (v >= MODULUS) ? (v - MODULUS) : v;
        return r;
    endfunction

    // modulo 26 of an 11-bit sum by reciprocal multiply and one correction
    function automatic logic [LETTER_W-1:0] mod26_sum(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [10:0] qm;
        logic [10:0] r;
        prod = 23'(x) * 23'd2521;
        q    = prod[22:16];
        qm   = 11'(q) * 11'd26;
        r    = x - qm;
        if (r >= 11'd26)
        begin
            r = r - 11'd26;
        end
        return r[LETTER_W-1:0];
    endfunction

    // multiplicative inverse modulo 26, ok low when none exists
    function automatic inv_t inv26(input logic [LETTER_W-1:0] d);
        inv_t res;
        res.ok = 1'b1;
        case (d)
            5'd1:    res.value = 5'd1;
            5'd3:    res.value = 5'd9;
            5'd5:    res.value = 5'd21;
            5'd7:    res.value = 5'd15;
            5'd9:    res.value = 5'd3;
            5'd11:   res.value = 5'd19;
            5'd15:   res.value = 5'd7;
            5'd17:   res.value = 5'd23;
            5'd19:   res.value = 5'd11;
            5'd21:   res.value = 5'd5;
            5'd23:   res.value = 5'd17;
            5'd25:   res.value = 5'd25;
            default:
            begin
                res.ok    = 1'b0;
                res.value = 5'd0;
            end
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/hill_ctrl.sv
// controller state machine: pairing of letters and sequencing of the datapath
module hill_ctrl
    import hill_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    end_of_message,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DET  = 7'b0000010,
        S_ROW0 = 7'b0000100,
        S_SCL0 = 7'b0001000,
        S_ROW1 = 7'b0010000,
        S_SCL1 = 7'b0100000,
        S_LONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   holding_reg;
    logic   holding_next;

    // items are taken only between pairs
    assign in_stall = (state_reg != S_IDLE);

    // state and holding registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            holding_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            holding_reg <= holding_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        holding_next = holding_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.emit_kind = EMIT_MAC;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (holding_reg)
                    begin
                        cmd.load_second = 1'b1;
                        holding_next    = 1'b0;
                        state_next      = status.decrypt ? S_DET : S_ROW0;
                    end
                    else if (!end_of_message)
                    begin
                        cmd.load_first = 1'b1;
                        holding_next   = 1'b1;
                    end
                    else if (status.decrypt)
                    begin
                        cmd.load_first = 1'b1;
                        state_next     = S_LONE;
                    end
                    else
                    begin
                        cmd.load_first = 1'b1;
                        cmd.load_pad   = 1'b1;
                        state_next     = S_ROW0;
                    end
                end
            end
            S_DET:
            begin
                cmd.op        = OP_DET;
                cmd.latch_det = 1'b1;
                state_next    = S_ROW0;
            end
            S_ROW0:
            begin
                cmd.op = OP_ROW0;
                if (status.decrypt)
                begin
                    cmd.latch_t = 1'b1;
                    state_next  = S_SCL0;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_MAC;
                    state_next    = S_ROW1;
                end
            end
            S_SCL0:
            begin
                cmd.op = OP_SCALE;
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_SCALED;
                    state_next    = S_ROW1;
                end
            end
            S_ROW1:
            begin
                cmd.op = OP_ROW1;
                if (status.decrypt)
                begin
                    cmd.latch_t = 1'b1;
                    state_next  = S_SCL1;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_MAC;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SCL1:
            begin
                cmd.op = OP_SCALE;
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_SCALED;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_LONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_LONE;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/hill_dp.sv
// datapath: key registers, letter pair, shared modulo-26 mac and output register
module hill_dp
    import hill_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                write_enable,
    input  logic [INDEX_W-1:0]  write_index,
    input  logic [LETTER_W-1:0] write_data,
    input  logic [LETTER_W-1:0] letter,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [LETTER_W-1:0] out_letter,
    output logic                last_of_run,
    output logic                error
);

    logic [LETTER_W-1:0] k00_reg;
    logic [LETTER_W-1:0] k01_reg;
    logic [LETTER_W-1:0] k10_reg;
    logic [LETTER_W-1:0] k11_reg;
    logic                mode_reg;
    logic [LETTER_W-1:0] p0_reg;
    logic [LETTER_W-1:0] p1_reg;
    logic [LETTER_W-1:0] det_reg;
    logic [LETTER_W-1:0] t_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [LETTER_W-1:0] out_letter_reg;
    logic                out_last_reg;
    logic                out_error_reg;

    logic [LETTER_W-1:0] letter_mod;
    logic [LETTER_W-1:0] neg_k01;
    logic [LETTER_W-1:0] neg_k10;
    inv_t                dinv;
    logic [LETTER_W-1:0] x0;
    logic [LETTER_W-1:0] y0;
    logic [LETTER_W-1:0] x1;
    logic [LETTER_W-1:0] y1;
    logic [9:0]          prod0;
    logic [9:0]          prod1;
    logic [10:0]         mac_sum;
    logic [LETTER_W-1:0] mac_res;

    assign letter_mod = reduce26(letter);
    assign neg_k01    = MODULUS - k01_reg;
    assign neg_k10    = MODULUS - k10_reg;
    assign dinv       = inv26(det_reg);

    assign status.decrypt  = mode_reg;
    assign status.out_free = !out_valid_reg || !out_stall;

    // configuration registers, key entries stored reduced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k00_reg  <= 5'd1;
            k01_reg  <= 5'd0;
            k10_reg  <= 5'd0;
            k11_reg  <= 5'd1;
            mode_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_KEY_R0C0: k00_reg  <= reduce26(write_data);
                REG_KEY_R0C1: k01_reg  <= reduce26(write_data);
                REG_KEY_R1C0: k10_reg  <= reduce26(write_data);
                REG_KEY_R1C1: k11_reg  <= reduce26(write_data);
                REG_MODE:     mode_reg <= write_data[0];
                default:      ;
            endcase
        end
    end

    // mac operand selection; decrypt rows use the adjugate, scaled later
    always_comb
    begin
        x0 = '0;
        y0 = '0;
        x1 = '0;
        y1 = '0;
        case (cmd.op)
            OP_DET:
            begin
                x0 = k00_reg;
                y0 = k11_reg;
                x1 = neg_k01;
                y1 = k10_reg;
            end
            OP_ROW0:
            begin
                x0 = mode_reg ? k11_reg : k00_reg;
                y0 = p0_reg;
                x1 = mode_reg ? neg_k01 : k01_reg;
                y1 = p1_reg;
            end
            OP_ROW1:
            begin
                x0 = mode_reg ? neg_k10 : k10_reg;
                y0 = p0_reg;
                x1 = mode_reg ? k00_reg : k11_reg;
                y1 = p1_reg;
            end
            OP_SCALE:
            begin
                x0 = dinv.value;
                y0 = t_reg;
            end
            default:
            begin
                x0 = '0;
            end
        endcase
    end

    // shared multiply-accumulate and reduction
    assign prod0   = 10'(x0) * 10'(y0);
    assign prod1   = 10'(x1) * 10'(y1);
    assign mac_sum = 11'(prod0) + 11'(prod1);
    assign mac_res = mod26_sum(mac_sum);

    // letter pair and intermediate results
    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            p0_reg <= letter_mod;
        end
        if (cmd.load_second || cmd.load_pad)
        begin
            p1_reg <= cmd.load_pad ? PAD_LETTER : letter_mod;
        end
        if (cmd.latch_det)
        begin
            det_reg <= mac_res;
        end
        if (cmd.latch_t)
        begin
            t_reg <= mac_res;
        end
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_last_reg <= cmd.emit_last;
            case (cmd.emit_kind)
                EMIT_MAC:
                begin
                    out_letter_reg <= mac_res;
                    out_error_reg  <= 1'b0;
                end
                EMIT_SCALED:
                begin
                    out_letter_reg <= dinv.ok ? mac_res : 5'd0;
                    out_error_reg  <= !dinv.ok;
                end
                EMIT_LONE:
                begin
                    out_letter_reg <= p0_reg;
                    out_error_reg  <= 1'b1;
                end
                default:
                begin
                    out_letter_reg <= 5'd0;
                    out_error_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_letter  = out_letter_reg;
    assign last_of_run = out_last_reg;
    assign error       = out_error_reg;

endmodule

### hw/rtl/hill_cipher_2x2_mod26.sv
// top level of the 2x2 modulo-26 hill cipher block
//
// Input channel (in_valid/in_stall) takes one letter index per item, with
// end_of_message on the final letter. Letters are paired; a pair yields two
// result items on the output channel (out_valid/out_stall), the second with
// last_of_run set. An odd final letter is padded with X when encrypting, or
// returned alone with error set when decrypting. Keys with no inverse give
// zero letters flagged with error when decrypting.
// Configuration: write_enable, write_index, write_data; write only while idle.
// Sequence: the first letter of a pair is only stored. After the second letter
// the shared multiply-accumulate unit runs one row step per result when
// encrypting, and when decrypting the determinant, then two row and scale
// steps. Each result is registered and shows on the port in the cycle after
// it is computed. Input is stalled while a pair is being worked on; a stalled
// output holds the machine in its emitting step. A new item is taken while the
// last result still waits in the output register.
// Reset restores the identity key, encrypt mode and an empty pair.
module hill_cipher_2x2_mod26
    import hill_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                write_enable,
    input  logic [INDEX_W-1:0]  write_index,
    input  logic [LETTER_W-1:0] write_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [LETTER_W-1:0] letter,
    input  logic                end_of_message,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [LETTER_W-1:0] out_letter,
    output logic                last_of_run,
    output logic                error
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    hill_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .end_of_message (end_of_message),
        .in_stall       (in_stall),
        .status         (status),
        .cmd            (cmd)
    );

    // arithmetic and storage
    hill_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .letter       (letter),
        .cmd          (cmd),
        .status       (status),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_letter   (out_letter),
        .last_of_run  (last_of_run),
        .error        (error)
    );

endmodule

### hw/rtl/hill_checker.sv
// port-level checker for the hill cipher block and its bind
`include "assert_macros.svh"

module hill_checker
    import hill_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                end_of_message,
    input logic                out_valid,
    input logic                out_stall,
    input logic [LETTER_W-1:0] out_letter,
    input logic                last_of_run,
    input logic                error
);

    // every result letter is a valid index
    `HILL_ASSERT_NOW(a_letter_range, clk, rst_n, out_valid, out_letter < MODULUS)

    // a flagged first result of a pair comes only from a bad key and is zero
    `HILL_ASSERT_NOW(a_bad_key_zero, clk, rst_n, out_valid && error && !last_of_run,
        out_letter == 5'd0)

    // the final letter always starts work, so the input stalls next
    `HILL_ASSERT_NEXT(a_end_busy, clk, rst_n, in_valid && !in_stall && end_of_message,
        in_stall)

    // a stalled result holds
    `HILL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_letter) && $stable(last_of_run) && $stable(error))

endmodule

bind hill_cipher_2x2_mod26 hill_checker u_hill_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_letter     (out_letter),
    .last_of_run    (last_of_run),
    .error          (error)
);
